[hw/rtl/ole_pkg.sv]
// Shared types and constants for the ordered list engine.
`default_nettype none

package ole_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_END   = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0] length;
    logic [3:0] position;
    status_e    status;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: sequencer, entry store and output register.
`default_nettype none

// Bounded ordered list of signed 32-bit values held in a ring buffer, so
// inserts at the head or the tail touch a single entry. Every item returns
// one result (status, position, length). An insert, or a delete or search on
// an empty list, goes from the sequencer's result register to the output
// register, and the input is ready again once it has moved there. A delete or
// search walks the list through the single read port of the entry store, one
// entry a cycle, and then registers its result the same way. The compaction
// of a delete is done in the same pass through the write port. The input is
// not ready while an item is in progress. A finished result waits in the
// output register while the next item is taken. If the output register is
// still occupied, the sequencer holds its result and the input stays not
// ready until the receiver takes the waiting item.
module ordered_list_engine import ole_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // value[31:0]
  input  wire logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o   // status[1:0], position[5:2], length[10:6], zero
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_q;
  res_t              out_q;

  ole_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .LW       (LW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (cmd_e'(s_axis_tuser_i)),
    .in_value_i  (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ole_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.length, out_q.position, out_q.status};

endmodule

`default_nettype wire

[hw/rtl/ole_mem.sv]
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module ole_mem import ole_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ole_ctrl.sv]
// Sequencer: ring-buffer pointers, list length and the shared key compare.
`default_nettype none

module ole_ctrl import ole_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IW       = $clog2(CAPACITY),
  parameter int unsigned LW       = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cmd_e              in_cmd_i,
  input  wire logic [DATA_W-1:0] in_value_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o,
  output logic                   mem_we_o,
  output logic      [IW-1:0]     mem_waddr_o,
  output logic      [DATA_W-1:0] mem_wdata_o,
  output logic                   mem_re_o,
  output logic      [IW-1:0]     mem_raddr_o,
  input  wire logic [DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [IW-1:0] PTR_LAST = IW'(CAPACITY - 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(CAPACITY);

  state_e            state_q, state_d;
  logic [IW-1:0]     head_q, head_d;
  logic [LW-1:0]     len_q, len_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]     cmp_ptr_q, cmp_ptr_d;
  logic [IW-1:0]     prv_ptr_q, prv_ptr_d;
  logic              hit_q, hit_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic              del_q, del_d;
  logic [DATA_W-1:0] key_q, key_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              full;
  logic [IW-1:0]     head_dec;
  logic [IW-1:0]     cmp_ptr_inc;
  logic [LW:0]       tail_sum;
  logic [IW-1:0]     tail_ptr;
  logic              match;
  logic              last;
  logic [LW-1:0]     len_fin;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign full        = (len_q == LEN_FULL);
  assign head_dec    = (head_q == '0) ? PTR_LAST : head_q - IW'(1);
  assign cmp_ptr_inc = (cmp_ptr_q == PTR_LAST) ? '0 : cmp_ptr_q + IW'(1);
  assign tail_sum    = (LW+1)'(head_q) + (LW+1)'(len_q);
  assign tail_ptr    = (tail_sum >= (LW+1)'(CAPACITY)) ?
                       IW'(tail_sum - (LW+1)'(CAPACITY)) : IW'(tail_sum);
  assign match       = (mem_rdata_i == key_q);
  assign last        = (LW'(cmp_idx_q) == len_q - LW'(1));
  assign len_fin     = (del_q && (hit_q || match)) ? len_q - LW'(1) : len_q;

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    len_d       = len_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_ptr_d   = cmp_ptr_q;
    prv_ptr_d   = prv_ptr_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    del_d       = del_q;
    key_d       = key_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_ptr;
    mem_wdata_o = in_value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = cmp_ptr_inc;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.position = '0;
          res_d.length   = 5'(len_q);
          state_d        = ST_DONE;
          case (in_cmd_i)
            CMD_INS_FRONT, CMD_INS_END: begin
              if (full) begin
                res_d.status = STS_FULL;
              end else begin
                res_d.status = STS_OK;
                mem_we_o     = 1'b1;
                len_d        = len_q + LW'(1);
                res_d.length = 5'(len_q + LW'(1));
                if (in_cmd_i == CMD_INS_FRONT) begin
                  mem_waddr_o = head_dec;
                  head_d      = head_dec;
                end
              end
            end
            CMD_DELETE, CMD_SEARCH: begin
              if (len_q == '0) begin
                res_d.status = (in_cmd_i == CMD_DELETE) ? STS_EMPTY : STS_NOT_FOUND;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                cmp_idx_d   = '0;
                cmp_ptr_d   = head_q;
                prv_ptr_d   = head_q;
                hit_d       = 1'b0;
                pos_d       = '0;
                del_d       = (in_cmd_i == CMD_DELETE);
                key_d       = in_value_i;
                state_d     = ST_SCAN;
              end
            end
            default: begin
              res_d.status = STS_NOT_FOUND;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = cmp_ptr_inc;
        // In a delete, once the key has matched, each later entry moves one place towards the head.
        if (del_q && hit_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = prv_ptr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (!hit_q && match) begin
          hit_d = 1'b1;
          pos_d = cmp_idx_q;
        end
        cmp_idx_d = cmp_idx_q + IW'(1);
        cmp_ptr_d = cmp_ptr_inc;
        prv_ptr_d = cmp_ptr_q;
        if (last) begin
          len_d          = len_fin;
          res_d.length   = 5'(len_fin);
          res_d.status   = (hit_q || match) ? STS_OK : STS_NOT_FOUND;
          res_d.position = hit_q ? 4'(pos_q) : (match ? 4'(cmp_idx_q) : 4'd0);
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    cmp_ptr_q <= cmp_ptr_d;
    prv_ptr_q <= prv_ptr_d;
    hit_q     <= hit_d;
    pos_q     <= pos_d;
    del_q     <= del_d;
    key_q     <= key_d;
    res_q     <= res_d;
  end

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the ordered list engine: directed and random list commands against a shadow list.
`default_nettype none

module tb;
  import ole_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF + 8;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  ordered_list_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  logic [31:0] list_shadow[$];
  res_t        pending_results[$];
  logic [31:0] key_pool[6] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h0000_0001, 32'h5a5a_a5a5};

  int   send_idle_pct = 6;
  int   recv_idle_pct = 83;
  int   recv_hold_left = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   mismatch_count = 0;
  int   stall_cycles = 0;
  int   longest_list = 0;
  int   status_seen[4] = '{0, 0, 0, 0};
  bit   filling = 1'b1;
  res_t got_result;
  res_t want_result;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow list update for one command; returns the result the block owes.
  function automatic res_t apply_list_op(input cmd_e cmd, input logic [31:0] key);
    res_t r;
    int   hit;
    r.status   = STS_OK;
    r.position = '0;
    hit = -1;
    for (int i = 0; i < list_shadow.size(); i++) begin
      if (hit < 0 && list_shadow[i] == key) hit = i;
    end
    case (cmd)
      CMD_INS_FRONT: begin
        if (list_shadow.size() >= CAPACITY_DEF) r.status = STS_FULL;
        else list_shadow.push_front(key);
      end
      CMD_INS_END: begin
        if (list_shadow.size() >= CAPACITY_DEF) r.status = STS_FULL;
        else list_shadow.push_back(key);
      end
      CMD_DELETE: begin
        if (list_shadow.size() == 0) begin
          r.status = STS_EMPTY;
        end else if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          list_shadow.delete(hit);
          r.position = hit[3:0];
        end
      end
      default: begin
        if (hit < 0) r.status = STS_NOT_FOUND;
        else r.position = hit[3:0];
      end
    endcase
    r.length = 5'(list_shadow.size());
    return r;
  endfunction

  function automatic logic [31:0] pick_key(input bit for_insert);
    int r;
    r = $urandom_range(99);
    if (for_insert) begin
      if (r < 40) return key_pool[$urandom_range(5)];
      return $urandom;
    end
    if (list_shadow.size() > 0 && r < 70) return list_shadow[$urandom_range(list_shadow.size() - 1)];
    if (r < 85) return key_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at result %0d: %s expected %0d, got %0d",
               results_checked, what, want, got);
  endtask

  // Offers one item and returns once it has been accepted; tvalid stays high.
  task automatic send_item(input cmd_e cmd, input logic [31:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= key;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_list_op(cmd, key));
    items_sent++;
    if (list_shadow.size() > longest_list) longest_list = list_shadow.size();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_cases();
    send_item(CMD_SEARCH, 32'd5);
    send_item(CMD_DELETE, 32'd5);
    send_item(CMD_INS_END, 32'h7fff_ffff);
    send_item(CMD_INS_FRONT, 32'h8000_0000);
    send_item(CMD_INS_END, 32'hffff_ffff);
    send_item(CMD_INS_END, 32'h0000_0000);
    send_item(CMD_INS_FRONT, 32'h7fff_ffff);
    // duplicate key: first match from the head wins
    send_item(CMD_SEARCH, 32'h7fff_ffff);
    send_item(CMD_DELETE, 32'h7fff_ffff);
    send_item(CMD_SEARCH, 32'h7fff_ffff);
    send_item(CMD_DELETE, 32'h1234_5678);
    for (int k = 0; k < 12; k++)
      send_item((k % 2) ? CMD_INS_END : CMD_INS_FRONT, 32'h1000_0000 + k);
    send_item(CMD_INS_FRONT, 32'hdead_beef);
    send_item(CMD_INS_END, 32'hdead_beef);
    // tail entry sits at the last position
    send_item(CMD_SEARCH, 32'h1000_000b);
    send_item(CMD_DELETE, 32'h1000_000b);
    send_item(CMD_DELETE, 32'h1000_000a);
  endtask

  task automatic test_random_mix(input int n, input int s_pct, input int r_pct);
    cmd_e cmd;
    int   r;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n; k++) begin
      if (list_shadow.size() >= CAPACITY_DEF) filling = 1'b0;
      else if (list_shadow.size() == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 5) cmd = cmd_e'($urandom_range(3));
      else if (filling) cmd = (r < 60) ? cmd_e'($urandom_range(1)) :
                              (r < 80) ? CMD_DELETE : CMD_SEARCH;
      else cmd = (r < 25) ? cmd_e'($urandom_range(1)) :
                 (r < 75) ? CMD_DELETE : CMD_SEARCH;
      send_item(cmd, pick_key(cmd == CMD_INS_FRONT || cmd == CMD_INS_END));
    end
  endtask

  // Receiver held off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    recv_hold_left = HOLD_CYCLES;
    for (int k = 0; k < 30; k++)
      send_item(cmd_e'($urandom_range(3)), pick_key(k < 15));
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) send_item(cmd_e'($urandom_range(3)), pick_key(1'b0));
    wait_drained();
    for (int k = 0; k < 10; k++) send_item(cmd_e'($urandom_range(3)), pick_key(1'b0));
  endtask

  always @(negedge clk_i) begin
    if (recv_hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_result = res_t'(m_axis_tdata_o[10:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, tdata", -1, int'(m_axis_tdata_o));
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status)
          report_mismatch("status", int'(want_result.status), int'(got_result.status));
        if (got_result.position !== want_result.position)
          report_mismatch("position", int'(want_result.position), int'(got_result.position));
        if (got_result.length !== want_result.length)
          report_mismatch("length", int'(want_result.length), int'(got_result.length));
        if (m_axis_tdata_o[15:11] !== 5'd0)
          report_mismatch("padding", 0, int'(m_axis_tdata_o[15:11]));
        status_seen[want_result.status]++;
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_edge_cases();
    test_random_mix(460, 6, 83);
    test_random_mix(460, 83, 6);
    test_backpressure();
    test_drain_pause();
    test_random_mix(430, 0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d items (directed, three idling phases, held receiver, pause); %0d results",
             items_sent, results_checked);
    $display("statuses: ok %0d, empty %0d, not found %0d, full %0d; longest list %0d",
             status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_NOT_FOUND],
             status_seen[STS_FULL], longest_list);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
